FILE: rtl/key_profile_correlation_detector_assert.svh
// Assertion macros for the key profile correlation detector.
`ifndef KEY_PROFILE_CORRELATION_DETECTOR_ASSERT_SVH
`define KEY_PROFILE_CORRELATION_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define KPCD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define KPCD_ASSERT_RST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("assertion failed");
`else
`define KPCD_ASSERT(label, clk, rst_n, prop)
`define KPCD_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: rtl/kpcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpcd_pkg
// Constants and the profile table of the key profile correlation detector.
// ----------------------------------------------------------------------------
package kpcd_pkg;
	localparam int CHROMA_WIDTH_DEF = 16;
	localparam int NBINS = 12;
	localparam int NKEYS = 24;
	localparam logic signed [15:0] THRESH_RESET = 16'sd16384;

	function automatic logic [15:0] profile_rom(input logic [4:0] idx);
		logic [15:0] v;
		case (idx)
			5'd0: v = 16'd26010;  5'd1: v = 16'd9134;   5'd2: v = 16'd14254;
			5'd3: v = 16'd9544;   5'd4: v = 16'd17940;  5'd5: v = 16'd16753;
			5'd6: v = 16'd10322;  5'd7: v = 16'd21258;  5'd8: v = 16'd9789;
			5'd9: v = 16'd14991;  5'd10: v = 16'd9380;  5'd11: v = 16'd11796;
			5'd12: v = 16'd25928; 5'd13: v = 16'd10977; 5'd14: v = 16'd14418;
			5'd15: v = 16'd22036; 5'd16: v = 16'd10650; 5'd17: v = 16'd14459;
			5'd18: v = 16'd10404; 5'd19: v = 16'd19456; 5'd20: v = 16'd16302;
			5'd21: v = 16'd11018; 5'd22: v = 16'd13681; 5'd23: v = 16'd12984;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

	// Tonic of the major key at position kk on the circle of fifths.
	function automatic logic [3:0] major_tonic(input logic [3:0] kk);
		logic [3:0] v;
		case (kk)
			4'd0: v = 4'd0;   4'd1: v = 4'd7;   4'd2: v = 4'd2;   4'd3: v = 4'd9;
			4'd4: v = 4'd4;   4'd5: v = 4'd11;  4'd6: v = 4'd6;   4'd7: v = 4'd1;
			4'd8: v = 4'd8;   4'd9: v = 4'd3;   4'd10: v = 4'd10; 4'd11: v = 4'd5;
			default: v = 4'd0;
		endcase
		return v;
	endfunction

	// Rotated profile entry for key index k (0..23) at bin j.
	function automatic logic [15:0] key_profile(input logic [4:0] k, input logic [3:0] j);
		logic [4:0] tonic;
		logic [4:0] base;
		logic [4:0] off;
		logic [4:0] s;
		logic [3:0] kk;
		if (k < 5'd12) begin
			kk = k[3:0];
			base = 5'd0;
			tonic = {1'b0, major_tonic(kk)};
		end else begin
			kk = 4'(k - 5'd12);
			base = 5'd12;
			tonic = {1'b0, major_tonic(kk)} + 5'd9;
			if (tonic >= 5'd12) begin
				tonic = tonic - 5'd12;
			end
		end
		s = {1'b0, j} + 5'd12 - tonic;
		off = (s >= 5'd12) ? s - 5'd12 : s;
		return profile_rom(base + off);
	endfunction

	typedef struct packed {
		logic start;
		logic busy;
	} kpcd_ctl_t;
endpackage

FILE: rtl/key_profile_correlation_detector.sv
`timescale 1ns / 1ps
// An item with a pitch class below 12 writes one chroma bin. The item marked last starts
// the key decision: for each of the 24 keys, the sequencer reads the 12 bins from the
// store and accumulates the sums, forms the variances and the cross term, forms the two
// products in a shift-and-add pass, and runs the root search over 16 bits; a key whose
// chroma or profile variance is zero skips the products and the root search. The result
// then waits for ready, and a sweep clears the store, as it also does after reset. No
// item is accepted from the last item of a vector until that sweep ends.
// ----------------------------------------------------------------------------
// key_profile_correlation_detector
// Top level: stream ports, threshold register, store, sequencer, output register.
// ----------------------------------------------------------------------------
`include "key_profile_correlation_detector_assert.svh"
module key_profile_correlation_detector import kpcd_pkg::*; #(
	parameter int CHROMA_WIDTH = CHROMA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // pitch_class[3:0], chroma_value[19:4], zero fill
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // key_code[4:0], confidence[20:5], zero fill
	output logic        m_tuser    // key_valid
);
	typedef enum logic [1:0] {T_LOAD, T_RUN, T_OUT, T_CLR} top_t;
	top_t st_q;
	logic signed [15:0] thresh_q;
	logic [3:0] clr_q;
	logic we;
	logic [3:0] waddr;
	logic [CHROMA_WIDTH-1:0] wdata;
	logic [3:0] raddr;
	logic [CHROMA_WIDTH-1:0] rdata;
	kpcd_ctl_t ctl;
	logic done;
	logic [4:0] code;
	logic signed [15:0] conf;
	logic kv;
	logic acc;

	assign s_tready = (st_q == T_LOAD);
	assign acc = s_tvalid && s_tready;
	assign ctl.start = acc && s_tlast;
	assign ctl.busy = (st_q == T_RUN);

	always_comb begin
		if (st_q == T_CLR) begin
			we = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we = acc && (s_tdata[3:0] < 4'(NBINS));
			waddr = s_tdata[3:0];
			wdata = CHROMA_WIDTH'(s_tdata[19:4]);
		end
	end

	kpcd_store #(.CW(CHROMA_WIDTH)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	kpcd_corr #(.CW(CHROMA_WIDTH)) u_corr (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .raddr(raddr), .rdata(rdata),
		.thresh(thresh_q), .done(done), .key_code(code), .conf(conf), .key_valid(kv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_CLR;
			clr_q <= '0;
			thresh_q <= THRESH_RESET;
			m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				thresh_q <= signed'(cfg_wdata);
			end
			unique case (st_q)
				T_LOAD: if (ctl.start) st_q <= T_RUN;
				T_RUN: begin
					if (done) begin
						m_tvalid <= 1'b1;
						m_tdata <= {3'd0, conf, code};
						m_tuser <= kv;
						st_q <= T_OUT;
					end
				end
				T_OUT: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						clr_q <= '0;
						st_q <= T_CLR;
					end
				end
				default: begin
					clr_q <= clr_q + 4'd1;
					if (clr_q == 4'(NBINS - 1)) st_q <= T_LOAD;
				end
			endcase
		end
	end

	`KPCD_ASSERT(a_no_accept_busy, clk, arst_n, ctl.busy |-> !s_tready)
	`KPCD_ASSERT(a_done_in_run, clk, arst_n, done |-> ctl.busy)
	`KPCD_ASSERT(a_out_code, clk, arst_n, (m_tvalid && !m_tuser) |-> (m_tdata[4:0] == 5'd0))
endmodule

FILE: rtl/kpcd_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpcd_store
// Chroma bin memory with a registered read, written by the stream and by the top level's clearing sweep.
// ----------------------------------------------------------------------------
module kpcd_store import kpcd_pkg::*; #(
	parameter int CW = CHROMA_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic [3:0]    waddr,
	input  logic [CW-1:0] wdata,
	input  logic [3:0]    raddr,
	output logic [CW-1:0] rdata
);
	logic [CW-1:0] mem [NBINS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= (raddr < 4'(NBINS)) ? mem[raddr] : '0;
	end
endmodule

FILE: rtl/kpcd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpcd_sqrt
// Bit-serial search for the largest c with c*c*P <= R, one bit per pass.
// ----------------------------------------------------------------------------
module kpcd_sqrt import kpcd_pkg::*; #(
	parameter int PW = 72,
	parameter int RW = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [PW-1:0] p,
	input  logic [RW-1:0] r,
	output logic          done,
	output logic [16:0]   c
);
	localparam int HW = PW / 2;
	localparam int QW = HW + 17;

	typedef enum logic [2:0] {P_SQ, P_LL, P_HL, P_LH, P_HH, P_CMP} ph_t;
	ph_t ph_q;
	logic [PW-1:0] p_q;
	logic [RW-1:0] r_q;
	logic [16:0] c_q;
	logic [33:0] m_q;
	logic [3:0] bit_q;
	logic busy_q;
	logic [16:0] t;
	logic [HW-1:0] pa;
	logic [16:0] ma;
	logic [QW-1:0] prod;
	logic [RW-1:0] term;
	logic [RW-1:0] acc_q;

	assign t = c_q | (17'd1 << bit_q);

	// Product m*P is formed as four 17-bit-by-half-P partial products.
	always_comb begin
		pa = p_q[HW-1:0];
		ma = m_q[16:0];
		case (ph_q)
			P_HL: begin
				pa = p_q[PW-1:HW];
			end
			P_LH: begin
				ma = m_q[33:17];
			end
			P_HH: begin
				pa = p_q[PW-1:HW];
				ma = m_q[33:17];
			end
			default: begin
			end
		endcase
		prod = QW'(pa) * QW'(ma);
		case (ph_q)
			P_HL: term = RW'(prod) << HW;
			P_LH: term = RW'(prod) << 17;
			P_HH: term = RW'(prod) << (HW + 17);
			default: term = RW'(prod);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			ph_q <= P_SQ;
			bit_q <= '0;
			c_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				p_q <= p;
				r_q <= r;
				c_q <= '0;
				bit_q <= 4'd15;
				ph_q <= P_SQ;
			end else if (busy_q) begin
				unique case (ph_q)
					P_SQ: begin
						m_q <= 34'(t) * 34'(t);
						acc_q <= '0;
						ph_q <= P_LL;
					end
					P_LL: begin
						acc_q <= acc_q + term;
						ph_q <= P_HL;
					end
					P_HL: begin
						acc_q <= acc_q + term;
						ph_q <= P_LH;
					end
					P_LH: begin
						acc_q <= acc_q + term;
						ph_q <= P_HH;
					end
					P_HH: begin
						acc_q <= acc_q + term;
						ph_q <= P_CMP;
					end
					default: begin
						if (acc_q <= r_q) begin
							c_q <= t;
						end
						ph_q <= P_SQ;
						if (bit_q == 4'd0) begin
							busy_q <= 1'b0;
							done <= 1'b1;
						end else begin
							bit_q <= bit_q - 4'd1;
						end
					end
				endcase
			end
		end
	end
	assign c = c_q;
endmodule

FILE: rtl/kpcd_corr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpcd_corr
// Sequencer: accumulates sums per key from the store, then runs the root search unless a variance is zero.
// ----------------------------------------------------------------------------
module kpcd_corr import kpcd_pkg::*; #(
	parameter int CW = CHROMA_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kpcd_ctl_t           ctl,
	output logic [3:0]          raddr,
	input  logic [CW-1:0]       rdata,
	input  logic signed [15:0]  thresh,
	output logic                done,
	output logic [4:0]          key_code,
	output logic signed [15:0]  conf,
	output logic                key_valid
);
	localparam int SXW = CW + 4;
	localparam int SXXW = 2 * CW + 4;
	localparam int SXYW = CW + 20;
	localparam int VXW = 2 * CW + 8;
	localparam int NW = CW + 24;
	localparam int PW = VXW + 40;
	localparam int RW = 2 * NW + 31;
	localparam int ML = (NW > 40) ? NW : 40;
	localparam int MCW = $clog2(ML);

	typedef enum logic [2:0] {
		S_IDLE, S_ACC, S_V1, S_V2, S_MUL, S_ROOT, S_WAIT, S_NEXT
	} st_t;
	st_t st_q;
	logic [4:0] key_q;
	logic [3:0] j_q;
	logic iss_q;
	logic rv_q;
	logic [3:0] jr_q;
	logic [SXW-1:0] sx_q;
	logic [SXXW-1:0] sxx_q;
	logic [SXYW-1:0] sxy_q;
	logic [19:0] sy_q;
	logic [35:0] syy_q;
	logic [VXW-1:0] vx_q;
	logic [39:0] vy_q;
	logic [NW-1:0] mag_q;
	logic neg_q;
	logic [PW-1:0] p_q;
	logic [RW-1:0] r_q;
	logic [PW-1:0] pa_q;
	logic [ML-1:0] pb_q;
	logic [RW-1:0] ra_q;
	logic [ML-1:0] rb_q;
	logic [MCW-1:0] mc_q;
	logic sq_start_q;
	logic sq_done;
	logic [16:0] c;
	logic signed [15:0] best_q;
	logic [4:0] code_q;
	logic signed [15:0] rq;
	logic [15:0] y;
	logic [NW-1:0] a12;
	logic [NW-1:0] bsy;

	assign raddr = j_q;
	assign y = key_profile(key_q, jr_q);
	assign a12 = NW'(sxy_q) * NW'(12);
	assign bsy = NW'(sx_q) * NW'(sy_q);

	kpcd_sqrt #(.PW(PW), .RW(RW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start_q), .p(p_q), .r(r_q),
		.done(sq_done), .c(c)
	);

	always_comb begin
		if (neg_q) begin
			rq = -16'(signed'({1'b0, c[15:0]}));
		end else if (c > 17'd32767) begin
			rq = 16'sd32767;
		end else begin
			rq = signed'(c[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			done <= 1'b0;
			sq_start_q <= 1'b0;
			iss_q <= 1'b0;
			rv_q <= 1'b0;
			key_q <= '0;
			j_q <= '0;
		end else begin
			done <= 1'b0;
			sq_start_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (ctl.start) begin
						st_q <= S_ACC;
						key_q <= '0;
						j_q <= '0;
						iss_q <= 1'b1;
						rv_q <= 1'b0;
						jr_q <= '0;
						sx_q <= '0; sxx_q <= '0; sxy_q <= '0; sy_q <= '0; syy_q <= '0;
					end
				end
				S_ACC: begin
					if (iss_q) begin
						if (j_q != 4'(NBINS - 1)) begin
							j_q <= j_q + 4'd1;
						end else begin
							iss_q <= 1'b0;
						end
					end
					rv_q <= iss_q;
					if (rv_q) begin
						jr_q <= jr_q + 4'd1;
						sx_q <= sx_q + SXW'(rdata);
						sxx_q <= sxx_q + SXXW'(rdata) * SXXW'(rdata);
						sxy_q <= sxy_q + SXYW'(rdata) * SXYW'(y);
						sy_q <= sy_q + 20'(y);
						syy_q <= syy_q + 36'(y) * 36'(y);
					end else if (!iss_q) begin
						st_q <= S_V1;
					end
				end
				S_V1: begin
					vx_q <= VXW'(sxx_q) * VXW'(12) - VXW'(sx_q) * VXW'(sx_q);
					vy_q <= 40'(syy_q) * 40'd12 - 40'(sy_q) * 40'(sy_q);
					neg_q <= a12 < bsy;
					mag_q <= (a12 < bsy) ? bsy - a12 : a12 - bsy;
					st_q <= S_V2;
				end
				S_V2: begin
					p_q <= '0;
					r_q <= '0;
					pa_q <= PW'(vx_q);
					pb_q <= ML'(vy_q);
					ra_q <= RW'(mag_q) << 30;
					rb_q <= ML'(mag_q);
					mc_q <= '0;
					if (vx_q == '0 || vy_q == '0) begin
						st_q <= S_NEXT;
					end else begin
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (pb_q[0]) begin
						p_q <= p_q + pa_q;
					end
					if (rb_q[0]) begin
						r_q <= r_q + ra_q;
					end
					pa_q <= pa_q << 1;
					ra_q <= ra_q << 1;
					pb_q <= pb_q >> 1;
					rb_q <= rb_q >> 1;
					mc_q <= mc_q + MCW'(1);
					if (mc_q == MCW'(ML - 1)) begin
						st_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					sq_start_q <= 1'b1;
					st_q <= S_WAIT;
				end
				S_WAIT: begin
					if (sq_done) begin
						if (key_q == 5'd0 || rq > best_q) begin
							best_q <= rq;
							code_q <= key_q + 5'd1;
						end
						st_q <= S_ACC;
						if (key_q == 5'(NKEYS - 1)) begin
							st_q <= S_IDLE;
							done <= 1'b1;
						end
						key_q <= key_q + 5'd1;
						j_q <= '0; jr_q <= '0; iss_q <= 1'b1; rv_q <= 1'b0;
						sx_q <= '0; sxx_q <= '0; sxy_q <= '0; sy_q <= '0; syy_q <= '0;
					end
				end
				default: begin
					if (key_q == 5'd0 || 16'sd0 > best_q) begin
						best_q <= 16'sd0;
						code_q <= key_q + 5'd1;
					end
					st_q <= S_ACC;
					if (key_q == 5'(NKEYS - 1)) begin
						st_q <= S_IDLE;
						done <= 1'b1;
					end
					key_q <= key_q + 5'd1;
					j_q <= '0; jr_q <= '0; iss_q <= 1'b1; rv_q <= 1'b0;
					sx_q <= '0; sxx_q <= '0; sxy_q <= '0; sy_q <= '0; syy_q <= '0;
				end
			endcase
		end
	end

	assign conf = best_q;
	assign key_valid = best_q >= thresh;
	assign key_code = key_valid ? code_q : 5'd0;
endmodule
